FILE: hw/rtl/bap_pkg.sv
// Shared types and constants of the block average pixelizer.
// No dependencies; bap_if, bap_div and block_average_pixelizer import it.
`default_nettype none

package bap_pkg;

    localparam int PIX_W      = 8;
    localparam int SUM_W      = 28;
    localparam int AREA_W     = 21;
    localparam int CELL_IDX_W = 6;
    localparam int DIM_REG_W  = 11;
    localparam int CELL_REG_W = 7;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 11;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_IMAGE_WIDTH  = 2'd0,
        CFG_IMAGE_HEIGHT = 2'd1,
        CFG_CELLS_ACROSS = 2'd2,
        CFG_CELLS_DOWN   = 2'd3
    } cfg_reg_e;

    typedef enum logic [2:0] {
        S_IDLE,
        S_CX,
        S_WX,
        S_CY,
        S_WY,
        S_AREA,
        S_ACC,
        S_DIV
    } bap_state_t;

    typedef struct packed {
        logic              start;
        logic [SUM_W-1:0]  dividend;
        logic [AREA_W-1:0] divisor;
    } div_req_t;

    typedef struct packed {
        logic             busy;
        logic [SUM_W-1:0] quotient;
    } div_rsp_t;

endpackage

`default_nettype wire

FILE: hw/rtl/bap_if.sv
// Handshake interfaces of the pixelizer: pixel input, cell output, config write.
// Depends on bap_pkg for field widths.
`default_nettype none

interface bap_pixel_if
    import bap_pkg::*;
();
    logic             valid;
    logic             ready;
    logic [PIX_W-1:0] gray_pixel;
    logic             frame_start;

    modport source (output valid, output gray_pixel, output frame_start, input ready);
    modport sink (input valid, input gray_pixel, input frame_start, output ready);
endinterface

interface bap_cell_if
    import bap_pkg::*;
();
    logic                  valid;
    logic                  ready;
    logic [PIX_W-1:0]      cell_average;
    logic [CELL_IDX_W-1:0] cell_column;
    logic [CELL_IDX_W-1:0] cell_row;
    logic                  frame_done;

    modport source (output valid, output cell_average, output cell_column,
                    output cell_row, output frame_done, input ready);
    modport sink (input valid, input cell_average, input cell_column,
                  input cell_row, input frame_done, output ready);
endinterface

interface bap_cfg_if
    import bap_pkg::*;
();
    logic                  valid;
    logic                  ready;
    logic [CFG_IDX_W-1:0]  index;
    logic [CFG_DATA_W-1:0] data;

    modport source (output valid, output index, output data, input ready);
    modport sink (input valid, input index, input data, output ready);
endinterface

`default_nettype wire

FILE: hw/rtl/bap_ram.sv
// Generic single-port-write, single-port-read RAM with registered read data.
// No dependencies.
`default_nettype none

module bap_ram #(
    parameter int WIDTH = 28,
    parameter int DEPTH = 64
) (
    input  wire logic                                   clk,
    input  wire logic                                   we,
    input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
    input  wire logic [WIDTH-1:0]                       wdata,
    input  wire logic                                   re,
    input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
    output logic [WIDTH-1:0]                            rdata
);
    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata <= mem[raddr];
        end
    end
endmodule

`default_nettype wire

FILE: hw/rtl/bap_div.sv
// Restoring divider, one quotient bit per cycle, SUM_W quotient bits per division.
// Depends on bap_pkg for the request and response structs.
`default_nettype none

module bap_div
    import bap_pkg::*;
(
    input  wire logic clk,
    input  wire logic rst_n,
    input  wire div_req_t req,
    output div_rsp_t  rsp
);
    localparam int CNT_W = $clog2(SUM_W + 1);

    logic [AREA_W-1:0] rem_reg, rem_next;
    logic [SUM_W-1:0]  quo_reg, quo_next;
    logic [AREA_W-1:0] dvs_reg;
    logic [CNT_W-1:0]  cnt_reg;
    logic              busy_reg;
    logic [AREA_W:0]   trial;
    logic [AREA_W:0]   diff;

    always_comb
    begin
        trial = {rem_reg, quo_reg[SUM_W-1]};
        diff  = trial - {1'b0, dvs_reg};
        if (trial >= {1'b0, dvs_reg})
        begin
            rem_next = diff[AREA_W-1:0];
            quo_next = {quo_reg[SUM_W-2:0], 1'b1};
        end
        else
        begin
            rem_next = trial[AREA_W-1:0];
            quo_next = {quo_reg[SUM_W-2:0], 1'b0};
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else if (req.start)
        begin
            busy_reg <= 1'b1;
            cnt_reg  <= CNT_W'(SUM_W);
        end
        else if (busy_reg)
        begin
            cnt_reg <= cnt_reg - CNT_W'(1);
            if (cnt_reg == CNT_W'(1))
            begin
                busy_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (req.start)
        begin
            rem_reg <= '0;
            quo_reg <= req.dividend;
            dvs_reg <= req.divisor;
        end
        else if (busy_reg)
        begin
            rem_reg <= rem_next;
            quo_reg <= quo_next;
        end
    end

    assign rsp.busy     = busy_reg;
    assign rsp.quotient = quo_reg;
endmodule

`default_nettype wire

FILE: hw/rtl/block_average_pixelizer.sv
// Block average pixelizer: averages raster-order gray pixels over a grid of blocks.
// Depends on bap_pkg, bap_if, bap_ram and bap_div.
//
// A pixel outside the covered grid only advances the position. A pixel inside a block
// updates its column accumulator: it is read from the RAM and written back in the cycle
// after. The last pixel of a block then starts a division in the shared divider (one
// quotient bit per cycle), and the next request is not taken until the quotient has
// moved into the output register, which waits while the previous cell result is still
// there; a cell result waits in the output register while the next pixels are accepted.
// After reset and after each configuration write the block recomputes block width and
// height with the same divider and the block area as their product, during which no
// pixel and no further write is taken. A pending configuration write holds off the pixel input.
`default_nettype none

module block_average_pixelizer
    import bap_pkg::*;
#(
    parameter int MAX_CELLS  = 64,
    parameter int MAX_WIDTH  = 1024,
    parameter int MAX_HEIGHT = 1024
) (
    input  wire logic  clk,
    input  wire logic  rst_n,
    bap_pixel_if.sink  pixel_in,
    bap_cell_if.source cell_out,
    bap_cfg_if.sink    cfg
);
    localparam int MAX_DIM = (MAX_WIDTH > MAX_HEIGHT) ? MAX_WIDTH : MAX_HEIGHT;
    localparam int DW      = $clog2(MAX_DIM + 1);
    localparam int CW      = $clog2(MAX_CELLS + 1);
    localparam int AW      = (MAX_CELLS > 1) ? $clog2(MAX_CELLS) : 1;

    bap_state_t state_reg, state_next;

    logic [DIM_REG_W-1:0]  image_width_reg, image_height_reg;
    logic [CELL_REG_W-1:0] cells_across_reg, cells_down_reg;
    logic [DW-1:0]         bw_reg, bh_reg;
    logic [AREA_W-1:0]     area_reg;

    logic [DW-1:0] pc_reg, pr_reg, ox_reg, oy_reg;
    logic [CW-1:0] bcx_reg, bry_reg;
    logic [DW-1:0] pc_next, pr_next, ox_next, oy_next;
    logic [CW-1:0] bcx_next, bry_next;

    logic [PIX_W-1:0] pix_reg;
    logic             first_reg, last_reg, done_flag_reg;
    logic [CW-1:0]    col_reg, row_reg;

    logic                  out_valid_reg;
    logic [PIX_W-1:0]      avg_reg;
    logic [CELL_IDX_W-1:0] out_col_reg, out_row_reg;
    logic                  out_done_reg;

    logic [DW-1:0]     w_eff, h_eff;
    logic [CW-1:0]     cx_eff, cy_eff;
    logic [AREA_W-1:0] area_eff;

    logic [DW-1:0] pc, pr, ox, oy;
    logic [CW-1:0] bcx, bry;
    logic          in_blk, first, last, done_flag;
    logic [DW:0]   pc_inc, pr_inc, ox_inc, oy_inc;

    logic             accept, load_out, slot_free;
    logic [SUM_W-1:0] sum;
    logic [SUM_W-1:0] ram_rdata;
    logic             ram_we, ram_re;
    logic [2*DW-1:0]  area_prod;

    div_req_t div_req;
    div_rsp_t div_rsp;

    bap_ram #(
        .WIDTH (SUM_W),
        .DEPTH (MAX_CELLS)
    ) u_sums (
        .clk   (clk),
        .we    (ram_we),
        .waddr (col_reg[AW-1:0]),
        .wdata (sum),
        .re    (ram_re),
        .raddr (bcx[AW-1:0]),
        .rdata (ram_rdata)
    );

    bap_div u_div (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (div_req),
        .rsp   (div_rsp)
    );

    // effective geometry
    always_comb
    begin
        int w_i, h_i, cx_i, cy_i;
        w_i = int'(image_width_reg);
        h_i = int'(image_height_reg);
        if (w_i == 0) w_i = 1;
        if (w_i > MAX_WIDTH) w_i = MAX_WIDTH;
        if (h_i == 0) h_i = 1;
        if (h_i > MAX_HEIGHT) h_i = MAX_HEIGHT;
        cx_i = int'(cells_across_reg);
        if (cx_i == 0) cx_i = 1;
        if (cx_i > w_i) cx_i = w_i;
        if (cx_i > MAX_CELLS) cx_i = MAX_CELLS;
        cy_i = int'(cells_down_reg);
        if (cy_i == 0) cy_i = 1;
        if (cy_i > h_i) cy_i = h_i;
        if (cy_i > MAX_CELLS) cy_i = MAX_CELLS;
        w_eff    = DW'(w_i);
        h_eff    = DW'(h_i);
        cx_eff   = CW'(cx_i);
        cy_eff   = CW'(cy_i);
        area_eff = (area_reg == '0) ? AREA_W'(1) : area_reg;
    end

    // position of the incoming pixel and the next position
    always_comb
    begin
        pc  = pixel_in.frame_start ? '0 : pc_reg;
        pr  = pixel_in.frame_start ? '0 : pr_reg;
        ox  = pixel_in.frame_start ? '0 : ox_reg;
        oy  = pixel_in.frame_start ? '0 : oy_reg;
        bcx = pixel_in.frame_start ? '0 : bcx_reg;
        bry = pixel_in.frame_start ? '0 : bry_reg;

        in_blk    = (bcx < cx_eff) && (bry < cy_eff) && (ox < bw_reg) && (oy < bh_reg);
        first     = (ox == '0) && (oy == '0);
        last      = (ox == bw_reg - DW'(1)) && (oy == bh_reg - DW'(1));
        done_flag = (bcx == cx_eff - CW'(1)) && (bry == cy_eff - CW'(1));

        pc_inc = {1'b0, pc} + (DW+1)'(1);
        pr_inc = {1'b0, pr} + (DW+1)'(1);
        ox_inc = {1'b0, ox} + (DW+1)'(1);
        oy_inc = {1'b0, oy} + (DW+1)'(1);

        pc_next  = pc;
        pr_next  = pr;
        ox_next  = ox;
        oy_next  = oy;
        bcx_next = bcx;
        bry_next = bry;
        if (pc_inc >= {1'b0, w_eff})
        begin
            pc_next  = '0;
            ox_next  = '0;
            bcx_next = '0;
            if (pr_inc >= {1'b0, h_eff})
            begin
                pr_next  = '0;
                oy_next  = '0;
                bry_next = '0;
            end
            else
            begin
                pr_next = pr_inc[DW-1:0];
                if (bry < cy_eff)
                begin
                    if (oy_inc >= {1'b0, bh_reg})
                    begin
                        oy_next  = '0;
                        bry_next = bry + CW'(1);
                    end
                    else
                    begin
                        oy_next = oy_inc[DW-1:0];
                    end
                end
            end
        end
        else
        begin
            pc_next = pc_inc[DW-1:0];
            if (bcx < cx_eff)
            begin
                if (ox_inc >= {1'b0, bw_reg})
                begin
                    ox_next  = '0;
                    bcx_next = bcx + CW'(1);
                end
                else
                begin
                    ox_next = ox_inc[DW-1:0];
                end
            end
        end
    end

    assign accept    = pixel_in.valid && pixel_in.ready;
    assign slot_free = !out_valid_reg || cell_out.ready;
    assign sum       = first_reg ? SUM_W'(pix_reg) : ram_rdata + SUM_W'(pix_reg);
    assign area_prod = bw_reg * bh_reg;

    always_comb
    begin
        state_next       = state_reg;
        div_req.start    = 1'b0;
        div_req.dividend = SUM_W'(w_eff);
        div_req.divisor  = AREA_W'(cx_eff);
        ram_we           = 1'b0;
        ram_re           = 1'b0;
        load_out         = 1'b0;
        unique case (state_reg)
            S_IDLE:
            begin
                if (cfg.valid)
                begin
                    state_next = S_CX;
                end
                else if (accept && in_blk)
                begin
                    ram_re     = 1'b1;
                    state_next = S_ACC;
                end
            end
            S_CX:
            begin
                div_req.start = 1'b1;
                state_next    = S_WX;
            end
            S_WX:
            begin
                if (!div_rsp.busy)
                begin
                    state_next = S_CY;
                end
            end
            S_CY:
            begin
                div_req.start    = 1'b1;
                div_req.dividend = SUM_W'(h_eff);
                div_req.divisor  = AREA_W'(cy_eff);
                state_next       = S_WY;
            end
            S_WY:
            begin
                if (!div_rsp.busy)
                begin
                    state_next = S_AREA;
                end
            end
            S_AREA:
            begin
                state_next = S_IDLE;
            end
            S_ACC:
            begin
                ram_we           = 1'b1;
                div_req.start    = last_reg;
                div_req.dividend = sum;
                div_req.divisor  = area_eff;
                state_next       = last_reg ? S_DIV : S_IDLE;
            end
            S_DIV:
            begin
                // hold the quotient until the division ends and the output register frees up
                if (!div_rsp.busy && slot_free)
                begin
                    load_out   = 1'b1;
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_CX;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            image_width_reg  <= DIM_REG_W'(640);
            image_height_reg <= DIM_REG_W'(480);
            cells_across_reg <= CELL_REG_W'(10);
            cells_down_reg   <= CELL_REG_W'(6);
        end
        else if (cfg.valid && cfg.ready)
        begin
            unique case (cfg_reg_e'(cfg.index))
                CFG_IMAGE_WIDTH:  image_width_reg  <= cfg.data;
                CFG_IMAGE_HEIGHT: image_height_reg <= cfg.data;
                CFG_CELLS_ACROSS: cells_across_reg <= cfg.data[CELL_REG_W-1:0];
                CFG_CELLS_DOWN:   cells_down_reg   <= cfg.data[CELL_REG_W-1:0];
                default:          image_width_reg  <= image_width_reg;
            endcase
        end
    end

    always_ff @(posedge clk)
    begin
        if (state_reg == S_WX && !div_rsp.busy)
        begin
            bw_reg <= div_rsp.quotient[DW-1:0];
        end
        if (state_reg == S_WY && !div_rsp.busy)
        begin
            bh_reg <= div_rsp.quotient[DW-1:0];
        end
        if (state_reg == S_AREA)
        begin
            area_reg <= AREA_W'(area_prod);
        end
        if (accept)
        begin
            pix_reg       <= pixel_in.gray_pixel;
            first_reg     <= first;
            last_reg      <= last;
            done_flag_reg <= done_flag;
            col_reg       <= bcx;
            row_reg       <= bry;
        end
        if (load_out)
        begin
            avg_reg      <= div_rsp.quotient[PIX_W-1:0];
            out_col_reg  <= CELL_IDX_W'(col_reg);
            out_row_reg  <= CELL_IDX_W'(row_reg);
            out_done_reg <= done_flag_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pc_reg        <= '0;
            pr_reg        <= '0;
            ox_reg        <= '0;
            oy_reg        <= '0;
            bcx_reg       <= '0;
            bry_reg       <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (accept)
            begin
                pc_reg  <= pc_next;
                pr_reg  <= pr_next;
                ox_reg  <= ox_next;
                oy_reg  <= oy_next;
                bcx_reg <= bcx_next;
                bry_reg <= bry_next;
            end
            if (load_out)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (cell_out.ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    assign pixel_in.ready        = (state_reg == S_IDLE) && !cfg.valid;
    assign cfg.ready             = (state_reg == S_IDLE);
    assign cell_out.valid        = out_valid_reg;
    assign cell_out.cell_average = avg_reg;
    assign cell_out.cell_column  = out_col_reg;
    assign cell_out.cell_row     = out_row_reg;
    assign cell_out.frame_done   = out_done_reg;

    a_acc_next: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_ACC) |=> (state_reg == S_IDLE || state_reg == S_DIV))
        else $error("accumulate step did not return to idle or divide");

    a_out_from_div: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid_reg) |-> ($past(state_reg) == S_DIV))
        else $error("cell result raised outside the divide step");

    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && !cell_out.ready) |=> out_valid_reg)
        else $error("stalled cell result dropped");

    a_idle_div_free: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_IDLE) |-> !div_rsp.busy)
        else $error("divider busy while idle");

endmodule

`default_nettype wire
